[rtl/pecu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pecu_pkg;

   localparam int COORD_W     = 16;
   localparam int INDEX_W     = 10;
   localparam int OPCODE_W    = 2;
   localparam int INTENSITY_W = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [OPCODE_W-1:0] OP_VERTEX = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_INDEX  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_END    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_CULL_ENABLE     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_BRIGHTNESS = 1'd1;

   localparam logic                   CULL_ENABLE_RESET     = 1'b1;
   localparam logic [INTENSITY_W-1:0] LINE_BRIGHTNESS_RESET = 16'hFFFF;

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_CULL_ADDR = 9'b000000010,
      S_CULL_USE  = 9'b000000100,
      S_MUL_A     = 9'b000001000,
      S_MUL_B     = 9'b000010000,
      S_DECIDE    = 9'b000100000,
      S_EMIT_ADDR = 9'b001000000,
      S_EMIT_USE  = 9'b010000000,
      S_CLOSE     = 9'b100000000
   } state_type;

endpackage

`default_nettype wire

[rtl/polygon_edge_emitter_culled_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Carries
// req_      in         req_valid/req_stall   opcode, vertex_index, view x/y, screen x/y
// rsp_      out        rsp_valid/rsp_stall   segment endpoints, intensity, flags
// csr_      in         csr_valid/csr_ready   register index and write data
//
// Vertex, face index and unused opcode transactions complete without leaving idle.
// An end of face with culling reads three vertices (an address and a use state each),
// runs the shared multiplier twice, then decides whether the face is drawn.
// Emission reads one vertex per segment from the single table read port, through an
// address and a use state per vertex, and a closing state returns to the first vertex.
// Reset is synchronous; a stalled result holds the sequencer until it is taken.

module polygon_edge_emitter_culled_unit
   import pecu_pkg::*;
#(
   parameter int VERTEX_DEPTH   = 1024,
   parameter int MAX_FACE_VERTS = 16,
   parameter int COORD_BITS     = 16
) (
   input  wire                          clock,
   input  wire                          reset,

   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [OPCODE_W-1:0]          req_opcode,
   input  wire  [INDEX_W-1:0]           req_vertex_index,
   input  wire  signed [COORD_W-1:0]    req_view_x,
   input  wire  signed [COORD_W-1:0]    req_view_y,
   input  wire  signed [COORD_W-1:0]    req_screen_x,
   input  wire  signed [COORD_W-1:0]    req_screen_y,

   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic signed [COORD_W-1:0]    rsp_start_x,
   output logic signed [COORD_W-1:0]    rsp_start_y,
   output logic signed [COORD_W-1:0]    rsp_end_x,
   output logic signed [COORD_W-1:0]    rsp_end_y,
   output logic [INTENSITY_W-1:0]       rsp_intensity,
   output logic                         rsp_last_segment,
   output logic                         rsp_overflowed,

   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [CSR_INDEX_W-1:0]       csr_index,
   input  wire  [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int SB  = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
   localparam int VW  = 4 * SB;
   localparam int AW  = $clog2(VERTEX_DEPTH);
   localparam int PW  = $clog2(MAX_FACE_VERTS);
   localparam int LW  = $clog2(MAX_FACE_VERTS + 1);
   localparam int DW  = SB + 1;
   localparam int PRW = 2 * DW;

   logic [VW-1:0]      vertex_mem [VERTEX_DEPTH];
   logic [INDEX_W-1:0] face_slot [MAX_FACE_VERTS];

   state_type state_ff, state_in;
   logic [LW-1:0] face_len_ff, face_len_in;
   logic          face_ovf_ff, face_ovf_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic          cull_en_ff, cull_en_in;
   logic [INTENSITY_W-1:0] bright_ff, bright_in;

   logic [VW-1:0] rd_data_ff;
   logic          rd_zero_ff;

   logic signed [SB-1:0]  base_x_ff, base_x_in;
   logic signed [SB-1:0]  base_y_ff, base_y_in;
   logic signed [DW-1:0]  ux_ff, ux_in, uy_ff, uy_in;
   logic signed [DW-1:0]  wx_ff, wx_in, wy_ff, wy_in;
   logic signed [PRW-1:0] prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;

   logic signed [SB-1:0] first_sx_ff, first_sx_in, first_sy_ff, first_sy_in;
   logic signed [SB-1:0] prev_sx_ff, prev_sx_in, prev_sy_ff, prev_sy_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] out_sx_ff, out_sx_in, out_sy_ff, out_sy_in;
   logic signed [COORD_W-1:0] out_ex_ff, out_ex_in, out_ey_ff, out_ey_in;
   logic [INTENSITY_W-1:0]    out_int_ff, out_int_in;
   logic                      out_last_ff, out_last_in;
   logic                      out_ovf_ff, out_ovf_in;

   logic                 req_take;
   logic                 vtx_we;
   logic                 slot_we;
   logic [INDEX_W-1:0]   slot_sel;
   logic                 rd_en;
   logic [VW-1:0]        vert;
   logic signed [SB-1:0] cur_vx, cur_vy, cur_sx, cur_sy;
   logic signed [DW-1:0] diff_x, diff_y;
   logic signed [DW-1:0] mul_a, mul_b;
   logic signed [PRW-1:0] mul_p;
   logic                 out_free;
   logic                 ptr_last;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign vtx_we  = req_take && (req_opcode == OP_VERTEX)
                    && (32'(req_vertex_index) < 32'(VERTEX_DEPTH));
   assign slot_we = req_take && (req_opcode == OP_INDEX)
                    && (face_len_ff < LW'(MAX_FACE_VERTS));

   assign slot_sel = face_slot[ptr_ff];
   assign rd_en    = (state_ff == S_CULL_ADDR) || (state_ff == S_EMIT_ADDR);

   always_ff @(posedge clock) begin
      if (vtx_we) begin
         vertex_mem[AW'(req_vertex_index)] <= {req_view_x[SB-1:0], req_view_y[SB-1:0],
                                               req_screen_x[SB-1:0], req_screen_y[SB-1:0]};
      end
      if (rd_en) begin
         rd_data_ff <= vertex_mem[AW'(slot_sel)];
         rd_zero_ff <= !(32'(slot_sel) < 32'(VERTEX_DEPTH));
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         face_slot[PW'(face_len_ff)] <= req_vertex_index;
      end
   end

   assign vert   = rd_zero_ff ? '0 : rd_data_ff;
   assign cur_vx = vert[4*SB-1:3*SB];
   assign cur_vy = vert[3*SB-1:2*SB];
   assign cur_sx = vert[2*SB-1:SB];
   assign cur_sy = vert[SB-1:0];

   assign diff_x = DW'(cur_vx) - DW'(base_x_ff);
   assign diff_y = DW'(cur_vy) - DW'(base_y_ff);

   assign mul_a = (state_ff == S_MUL_A) ? ux_ff : uy_ff;
   assign mul_b = (state_ff == S_MUL_A) ? wy_ff : wx_ff;
   assign mul_p = PRW'(mul_a) * PRW'(mul_b);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign ptr_last = (LW'(ptr_ff) == face_len_ff - LW'(1));

   always_comb begin
      state_in    = state_ff;
      face_len_in = face_len_ff;
      face_ovf_in = face_ovf_ff;
      ptr_in      = ptr_ff;
      cull_en_in  = cull_en_ff;
      bright_in   = bright_ff;
      base_x_in   = base_x_ff;
      base_y_in   = base_y_ff;
      ux_in       = ux_ff;
      uy_in       = uy_ff;
      wx_in       = wx_ff;
      wy_in       = wy_ff;
      prod_a_in   = prod_a_ff;
      prod_b_in   = prod_b_ff;
      first_sx_in = first_sx_ff;
      first_sy_in = first_sy_ff;
      prev_sx_in  = prev_sx_ff;
      prev_sy_in  = prev_sy_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_sx_in   = out_sx_ff;
      out_sy_in   = out_sy_ff;
      out_ex_in   = out_ex_ff;
      out_ey_in   = out_ey_ff;
      out_int_in  = out_int_ff;
      out_last_in = out_last_ff;
      out_ovf_in  = out_ovf_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CULL_ENABLE:     cull_en_in = csr_wdata[0];
            CSR_LINE_BRIGHTNESS: bright_in  = csr_wdata[INTENSITY_W-1:0];
            default:             ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_opcode)
                  OP_INDEX: begin
                     if (slot_we) begin
                        face_len_in = face_len_ff + LW'(1);
                     end else begin
                        face_ovf_in = 1'b1;
                     end
                  end
                  OP_END: begin
                     ptr_in = '0;
                     if (face_len_ff < LW'(2)) begin
                        face_len_in = '0;
                        face_ovf_in = 1'b0;
                     end else if (cull_en_ff && face_len_ff >= LW'(3)) begin
                        state_in = S_CULL_ADDR;
                     end else begin
                        state_in = S_EMIT_ADDR;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CULL_ADDR: begin
            state_in = S_CULL_USE;
         end
         S_CULL_USE: begin
            if (ptr_ff == PW'(0)) begin
               base_x_in = cur_vx;
               base_y_in = cur_vy;
               ptr_in    = ptr_ff + PW'(1);
               state_in  = S_CULL_ADDR;
            end else if (ptr_ff == PW'(1)) begin
               ux_in    = diff_x;
               uy_in    = diff_y;
               ptr_in   = ptr_ff + PW'(1);
               state_in = S_CULL_ADDR;
            end else begin
               wx_in    = diff_x;
               wy_in    = diff_y;
               state_in = S_MUL_A;
            end
         end
         S_MUL_A: begin
            prod_a_in = mul_p;
            state_in  = S_MUL_B;
         end
         S_MUL_B: begin
            prod_b_in = mul_p;
            state_in  = S_DECIDE;
         end
         S_DECIDE: begin
            ptr_in = '0;
            if (prod_a_ff > prod_b_ff) begin
               state_in = S_EMIT_ADDR;
            end else begin
               face_len_in = '0;
               face_ovf_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         S_EMIT_ADDR: begin
            state_in = S_EMIT_USE;
         end
         S_EMIT_USE: begin
            if (ptr_ff == PW'(0)) begin
               first_sx_in = cur_sx;
               first_sy_in = cur_sy;
               prev_sx_in  = cur_sx;
               prev_sy_in  = cur_sy;
               ptr_in      = ptr_ff + PW'(1);
               state_in    = S_EMIT_ADDR;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               out_sx_in    = COORD_W'(prev_sx_ff);
               out_sy_in    = COORD_W'(prev_sy_ff);
               out_ex_in    = COORD_W'(cur_sx);
               out_ey_in    = COORD_W'(cur_sy);
               out_int_in   = bright_ff;
               out_last_in  = 1'b0;
               out_ovf_in   = face_ovf_ff;
               prev_sx_in   = cur_sx;
               prev_sy_in   = cur_sy;
               if (ptr_last) begin
                  state_in = S_CLOSE;
               end else begin
                  ptr_in   = ptr_ff + PW'(1);
                  state_in = S_EMIT_ADDR;
               end
            end
         end
         S_CLOSE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_sx_in    = COORD_W'(prev_sx_ff);
               out_sy_in    = COORD_W'(prev_sy_ff);
               out_ex_in    = COORD_W'(first_sx_ff);
               out_ey_in    = COORD_W'(first_sy_ff);
               out_int_in   = bright_ff;
               out_last_in  = 1'b1;
               out_ovf_in   = face_ovf_ff;
               face_len_in  = '0;
               face_ovf_in  = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         face_len_ff  <= '0;
         face_ovf_ff  <= 1'b0;
         ptr_ff       <= '0;
         cull_en_ff   <= CULL_ENABLE_RESET;
         bright_ff    <= LINE_BRIGHTNESS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         face_len_ff  <= face_len_in;
         face_ovf_ff  <= face_ovf_in;
         ptr_ff       <= ptr_in;
         cull_en_ff   <= cull_en_in;
         bright_ff    <= bright_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_x_ff   <= base_x_in;
      base_y_ff   <= base_y_in;
      ux_ff       <= ux_in;
      uy_ff       <= uy_in;
      wx_ff       <= wx_in;
      wy_ff       <= wy_in;
      prod_a_ff   <= prod_a_in;
      prod_b_ff   <= prod_b_in;
      first_sx_ff <= first_sx_in;
      first_sy_ff <= first_sy_in;
      prev_sx_ff  <= prev_sx_in;
      prev_sy_ff  <= prev_sy_in;
      out_sx_ff   <= out_sx_in;
      out_sy_ff   <= out_sy_in;
      out_ex_ff   <= out_ex_in;
      out_ey_ff   <= out_ey_in;
      out_int_ff  <= out_int_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_start_x      = out_sx_ff;
   assign rsp_start_y      = out_sy_ff;
   assign rsp_end_x        = out_ex_ff;
   assign rsp_end_y        = out_ey_ff;
   assign rsp_intensity    = out_int_ff;
   assign rsp_last_segment = out_last_ff;
   assign rsp_overflowed   = out_ovf_ff;

endmodule

`default_nettype wire

[bench/pecu_segment_checker.sv]
`timescale 1ns / 1ps

module pecu_segment_checker
   import pecu_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024,
   parameter int FACE_CAP    = 16
) (
   input  wire                         clock,
   input  wire                         reset,

   input  wire                         req_valid,
   input  wire                         req_stall,
   input  wire  [OPCODE_W-1:0]         req_opcode,
   input  wire  [INDEX_W-1:0]          req_vertex_index,
   input  wire  signed [COORD_W-1:0]   req_view_x,
   input  wire  signed [COORD_W-1:0]   req_view_y,
   input  wire  signed [COORD_W-1:0]   req_screen_x,
   input  wire  signed [COORD_W-1:0]   req_screen_y,

   input  wire                         rsp_valid,
   input  wire                         rsp_stall,
   input  wire  signed [COORD_W-1:0]   rsp_start_x,
   input  wire  signed [COORD_W-1:0]   rsp_start_y,
   input  wire  signed [COORD_W-1:0]   rsp_end_x,
   input  wire  signed [COORD_W-1:0]   rsp_end_y,
   input  wire  [INTENSITY_W-1:0]      rsp_intensity,
   input  wire                         rsp_last_segment,
   input  wire                         rsp_overflowed,

   input  wire                         csr_valid,
   input  wire                         csr_ready,
   input  wire  [CSR_INDEX_W-1:0]      csr_index,
   input  wire  [CSR_DATA_W-1:0]       csr_wdata,

   output int                          mismatch_count,
   output int                          segments_waiting,
   output int                          segments_checked
);

   typedef struct packed {
      logic signed [COORD_W-1:0] view_x;
      logic signed [COORD_W-1:0] view_y;
      logic signed [COORD_W-1:0] screen_x;
      logic signed [COORD_W-1:0] screen_y;
   } vertex_entry_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic [INTENSITY_W-1:0]    intensity;
      logic                      last_segment;
      logic                      overflowed;
   } segment_type;

   vertex_entry_type       vertex_table [TABLE_DEPTH];
   logic [INDEX_W-1:0]     face_list [FACE_CAP];
   int unsigned            face_count;
   logic                   face_dropped;
   logic                   cull_on;
   logic [INTENSITY_W-1:0] brightness;
   segment_type            segment_queue [$];
   segment_type            oldest;

   function automatic vertex_entry_type fetch_vertex(input logic [INDEX_W-1:0] slot);
      if (slot < TABLE_DEPTH) begin
         return vertex_table[slot];
      end
      return '0;
   endfunction

   // The face is kept when the z component of the cross product (b - a) x (c - a) of its
   // leading vertices a, b and c, taken in view space, is strictly positive.
   function automatic logic faces_viewer();
      vertex_entry_type a;
      vertex_entry_type b;
      vertex_entry_type c;
      longint           ux;
      longint           uy;
      longint           wx;
      longint           wy;
      a  = fetch_vertex(face_list[0]);
      b  = fetch_vertex(face_list[1]);
      c  = fetch_vertex(face_list[2]);
      ux = longint'(b.view_x) - longint'(a.view_x);
      uy = longint'(b.view_y) - longint'(a.view_y);
      wx = longint'(c.view_x) - longint'(a.view_x);
      wy = longint'(c.view_y) - longint'(a.view_y);
      return (ux * wy - uy * wx) > 0;
   endfunction

   task automatic close_face();
      vertex_entry_type p;
      vertex_entry_type q;
      segment_type      seg;
      logic             draw;
      int unsigned      j;
      if (face_count < 2) begin
         draw = 1'b0;
      end else if (cull_on && face_count >= 3) begin
         draw = faces_viewer();
      end else begin
         draw = 1'b1;
      end
      if (draw) begin
         for (j = 0; j < face_count; j++) begin
            p                = fetch_vertex(face_list[j]);
            q                = fetch_vertex(face_list[(j + 1) % face_count]);
            seg.start_x      = p.screen_x;
            seg.start_y      = p.screen_y;
            seg.end_x        = q.screen_x;
            seg.end_y        = q.screen_y;
            seg.intensity    = brightness;
            seg.last_segment = (j + 1 == face_count);
            seg.overflowed   = face_dropped;
            segment_queue    = {segment_queue, seg};
         end
      end
      face_count   = 0;
      face_dropped = 1'b0;
   endtask

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         $error("Field %s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         face_count       = 0;
         face_dropped     = 1'b0;
         cull_on          = CULL_ENABLE_RESET;
         brightness       = LINE_BRIGHTNESS_RESET;
         mismatch_count   = 0;
         segments_checked = 0;
         segment_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CULL_ENABLE) begin
               cull_on = csr_wdata[0];
            end else if (csr_index == CSR_LINE_BRIGHTNESS) begin
               brightness = csr_wdata[INTENSITY_W-1:0];
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (segment_queue.size() == 0) begin
               $error("Segment transaction arrived with none expected");
               mismatch_count++;
            end else begin
               oldest = segment_queue.pop_front();
               check_field("start_x", oldest.start_x, rsp_start_x);
               check_field("start_y", oldest.start_y, rsp_start_y);
               check_field("end_x", oldest.end_x, rsp_end_x);
               check_field("end_y", oldest.end_y, rsp_end_y);
               check_field("intensity", oldest.intensity, rsp_intensity);
               check_field("last_segment", oldest.last_segment, rsp_last_segment);
               check_field("overflowed", oldest.overflowed, rsp_overflowed);
               segments_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            case (req_opcode)
               OP_VERTEX: begin
                  if (req_vertex_index < TABLE_DEPTH) begin
                     vertex_table[req_vertex_index].view_x   = req_view_x;
                     vertex_table[req_vertex_index].view_y   = req_view_y;
                     vertex_table[req_vertex_index].screen_x = req_screen_x;
                     vertex_table[req_vertex_index].screen_y = req_screen_y;
                  end
               end
               OP_INDEX: begin
                  if (face_count < FACE_CAP) begin
                     face_list[face_count] = req_vertex_index;
                     face_count++;
                  end else begin
                     face_dropped = 1'b1;
                  end
               end
               OP_END: begin
                  close_face();
               end
               default: begin
               end
            endcase
         end
      end
      segments_waiting <= segment_queue.size();
   end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
   import pecu_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   localparam int TABLE_DEPTH    = 1024;
   localparam int FACE_CAP       = 16;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 64;
   localparam int WATCHDOG_LIMIT = 5000;

   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_NEG = '1;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [OPCODE_W-1:0]        req_opcode = OP_VERTEX;
   logic [INDEX_W-1:0]         req_vertex_index = '0;
   logic signed [COORD_W-1:0]  req_view_x = '0;
   logic signed [COORD_W-1:0]  req_view_y = '0;
   logic signed [COORD_W-1:0]  req_screen_x = '0;
   logic signed [COORD_W-1:0]  req_screen_y = '0;

   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [COORD_W-1:0]  rsp_start_x;
   logic signed [COORD_W-1:0]  rsp_start_y;
   logic signed [COORD_W-1:0]  rsp_end_x;
   logic signed [COORD_W-1:0]  rsp_end_y;
   logic [INTENSITY_W-1:0]     rsp_intensity;
   logic                       rsp_last_segment;
   logic                       rsp_overflowed;

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   int                         mismatch_count;
   int                         segments_waiting;
   int                         segments_checked;

   int                         items_sent = 0;
   int                         faces_sent = 0;
   bit                         steady = 1'b0;
   bit                         squeeze = 1'b0;
   bit                         squeeze_done = 1'b0;
   int                         hold_left = 0;
   logic [INDEX_W-1:0]         stored_slots [$];
   bit                         slot_used [TABLE_DEPTH];

   polygon_edge_emitter_culled_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_vertex_index (req_vertex_index),
      .req_view_x       (req_view_x),
      .req_view_y       (req_view_y),
      .req_screen_x     (req_screen_x),
      .req_screen_y     (req_screen_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_start_x      (rsp_start_x),
      .rsp_start_y      (rsp_start_y),
      .rsp_end_x        (rsp_end_x),
      .rsp_end_y        (rsp_end_y),
      .rsp_intensity    (rsp_intensity),
      .rsp_last_segment (rsp_last_segment),
      .rsp_overflowed   (rsp_overflowed),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   pecu_segment_checker #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .FACE_CAP    (FACE_CAP)
   ) segment_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_vertex_index (req_vertex_index),
      .req_view_x       (req_view_x),
      .req_view_y       (req_view_y),
      .req_screen_x     (req_screen_x),
      .req_screen_y     (req_screen_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_start_x      (rsp_start_x),
      .rsp_start_y      (rsp_start_y),
      .rsp_end_x        (rsp_end_x),
      .rsp_end_y        (rsp_end_y),
      .rsp_intensity    (rsp_intensity),
      .rsp_last_segment (rsp_last_segment),
      .rsp_overflowed   (rsp_overflowed),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .segments_waiting (segments_waiting),
      .segments_checked (segments_checked)
   );

   always #5 clock = ~clock;

   // The long hold keeps the result side blocked while the bench keeps offering faces.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (squeeze && !squeeze_done) begin
         rsp_stall    <= 1'b1;
         hold_left    <= HOLD_CYCLES;
         squeeze_done <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 7);
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic signed [COORD_W-1:0] pick_coord();
      case ($urandom_range(9))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return '0;
         3: return COORD_NEG;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] slot,
                            input logic signed [COORD_W-1:0] vx,
                            input logic signed [COORD_W-1:0] vy,
                            input logic signed [COORD_W-1:0] sx,
                            input logic signed [COORD_W-1:0] sy);
      while (!steady && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_vertex_index <= slot;
      req_view_x       <= vx;
      req_view_y       <= vy;
      req_screen_x     <= sx;
      req_screen_y     <= sy;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic write_vertex(input logic [INDEX_W-1:0] slot,
                               input logic signed [COORD_W-1:0] vx,
                               input logic signed [COORD_W-1:0] vy,
                               input logic signed [COORD_W-1:0] sx,
                               input logic signed [COORD_W-1:0] sy);
      send_item(OP_VERTEX, slot, vx, vy, sx, sy);
      if (!slot_used[slot]) begin
         slot_used[slot] = 1'b1;
         stored_slots    = {stored_slots, slot};
      end
   endtask

   task automatic write_random_vertex();
      write_vertex(INDEX_W'($urandom_range(TABLE_DEPTH - 1)), pick_coord(), pick_coord(),
                   pick_coord(), pick_coord());
   endtask

   task automatic add_index(input logic [INDEX_W-1:0] slot);
      send_item(OP_INDEX, slot, COORD_W'($urandom), COORD_W'($urandom),
                COORD_W'($urandom), COORD_W'($urandom));
   endtask

   task automatic end_face();
      send_item(OP_END, INDEX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                COORD_W'($urandom), COORD_W'($urandom));
      faces_sent++;
   endtask

   // Only slots that have been written are ever referenced by a face.
   task automatic random_face(input int count);
      int k;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(15) == 0) begin
            write_random_vertex();
         end
         add_index(stored_slots[$urandom_range(stored_slots.size() - 1)]);
      end
      end_face();
   endtask

   task automatic set_mode(input logic cull, input logic [INTENSITY_W-1:0] bright);
      csr_valid <= 1'b1;
      csr_index <= CSR_CULL_ENABLE;
      csr_wdata <= {(CSR_DATA_W-1)'($urandom), cull};
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_LINE_BRIGHTNESS;
      csr_wdata <= bright;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (segments_waiting != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int count);
      int done_items;
      int n;
      done_items = 0;
      while (done_items < count) begin
         case ($urandom_range(19))
            0: begin
               send_item(OP_UNUSED, INDEX_W'($urandom), COORD_W'($urandom),
                         COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
            end
            1: begin
               add_index(stored_slots[$urandom_range(stored_slots.size() - 1)]);
               end_face();
               done_items += 2;
            end
            2: begin
               end_face();
               done_items++;
            end
            3, 4, 5: begin
               n = $urandom_range(1, 4);
               repeat (n) write_random_vertex();
               done_items += n;
            end
            default: begin
               n = ($urandom_range(9) == 0) ? $urandom_range(14, 20) : $urandom_range(2, 8);
               random_face(n);
               done_items += n + 1;
            end
         endcase
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_vertex(10'd0, '0, '0, COORD_MIN, COORD_MAX);
      write_vertex(10'd1023, COORD_MAX, '0, COORD_MAX, COORD_MIN);
      write_vertex(10'd512, '0, COORD_MAX, '0, COORD_NEG);
      write_vertex(10'd341, COORD_MIN, COORD_MIN, COORD_NEG, '0);
      add_index(10'd0);
      add_index(10'd1023);
      add_index(10'd512);
      end_face();
      add_index(10'd0);
      add_index(10'd512);
      add_index(10'd1023);
      end_face();
      add_index(10'd341);
      add_index(10'd1023);
      add_index(10'd512);
      end_face();
      add_index(10'd0);
      add_index(10'd1023);
      add_index(10'd0);
      end_face();
      add_index(10'd512);
      add_index(10'd0);
      end_face();
      add_index(10'd341);
      end_face();
      end_face();
      send_item(OP_UNUSED, '1, COORD_MIN, COORD_MAX, COORD_NEG, '0);
      drain();

      set_mode(1'b0, '0);
      run_phase(40);
      drain();

      set_mode(1'b1, '1);
      squeeze <= 1'b1;
      random_face(18);
      random_face(16);
      random_face(16);
      random_face(3);
      run_phase(25);
      drain();

      set_mode(1'b1, INTENSITY_W'($urandom));
      steady <= 1'b1;
      run_phase(40);
      drain();
      steady <= 1'b0;

      set_mode(1'b0, INTENSITY_W'($urandom));
      run_phase(40);
      drain();

      $display("Run covered %0d request transactions and %0d closed faces, %0d segments checked,",
               items_sent, faces_sent, segments_checked);
      $display("with culling on and off, brightness extremes and a long result-side hold.");
      if (mismatch_count == 0 && segments_waiting == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
